// File: rtl/dsaa_pkg.sv
// Shared types, codes and constants for the distance-sensor axis alignment block.
package dsaa_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [31:0] DEFAULT_RUN_LIMIT = 32'd5000;
    localparam logic [31:0] DEFAULT_SETTLE_MS = 32'd120;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_ABORT  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_RUN   = 3'd1,
        ST_OK    = 3'd2,
        ST_FAIL  = 3'd3,
        ST_ABORT = 3'd4
    } t_run_state;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_PARAM   = 3'd1,
        FLT_TIMEOUT = 3'd2,
        FLT_SENSOR  = 3'd3,
        FLT_ABORT   = 3'd4
    } t_fault;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET      = 3'd0,
        CFG_TOLERANCE   = 3'd1,
        CFG_GAIN        = 3'd2,
        CFG_DRIVE_LIMIT = 3'd3,
        CFG_WINDOW_LOW  = 3'd4,
        CFG_WINDOW_HIGH = 3'd5,
        CFG_TIMEOUT     = 3'd6,
        CFG_SETTLE      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        target_count;
        logic [15:0]        tolerance_count;
        logic signed [31:0] gain_q16;
        logic [14:0]        drive_limit;
        logic [15:0]        window_low;
        logic [15:0]        window_high;
        logic [31:0]        run_limit_ms;
        logic [31:0]        settle_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] now_ms;
        logic        mech_at_target;
        logic        sample_valid;
        logic [15:0] sample_count;
    } t_item;

    // Handshake between the input register and the core.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_stage;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               drive_valid;
        t_run_state         run_state;
        t_run_state         outcome;
        t_fault             fault_code;
        logic               phase;
        logic               start_accepted;
        logic signed [16:0] error_count;
    } t_result;

endpackage

// File: rtl/dsaa_cfg_regs.sv
// Configuration register file written through the plain write port.
module dsaa_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dsaa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dsaa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dsaa_pkg::t_cfg                    o_cfg
);
    import dsaa_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_count    <= '0;
            r_cfg.tolerance_count <= '0;
            r_cfg.gain_q16        <= '0;
            r_cfg.drive_limit     <= '0;
            r_cfg.window_low      <= '0;
            r_cfg.window_high     <= 16'hFFFF;
            r_cfg.run_limit_ms    <= DEFAULT_RUN_LIMIT;
            r_cfg.settle_ms       <= DEFAULT_SETTLE_MS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET:      r_cfg.target_count    <= i_cfg_data[15:0];
                CFG_TOLERANCE:   r_cfg.tolerance_count <= i_cfg_data[15:0];
                CFG_GAIN:        r_cfg.gain_q16        <= i_cfg_data;
                CFG_DRIVE_LIMIT: r_cfg.drive_limit     <= i_cfg_data[14:0];
                CFG_WINDOW_LOW:  r_cfg.window_low      <= i_cfg_data[15:0];
                CFG_WINDOW_HIGH: r_cfg.window_high     <= i_cfg_data[15:0];
                CFG_TIMEOUT:     r_cfg.run_limit_ms    <= i_cfg_data;
                CFG_SETTLE:      r_cfg.settle_ms       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/dsaa_in_reg.sv
// Input register that holds one command transaction until the core takes it.
module dsaa_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  dsaa_pkg::t_item       i_item,
    output dsaa_pkg::t_item_stage o_stage,
    input  logic                  i_take
);
    import dsaa_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// File: rtl/dsaa_drive.sv
// Proportional drive: error times Q16.16 gain, rounded and clamped to the drive limit.
module dsaa_drive (
    input  logic signed [16:0] i_error,
    input  logic signed [31:0] i_gain_q16,
    input  logic [14:0]        i_limit,
    output logic signed [15:0] o_drive
);
    import dsaa_pkg::*;

    logic        e_neg;
    logic        g_neg;
    logic [16:0] e_neg_val;
    logic [15:0] e_mag;
    logic [31:0] g_mag;
    logic [47:0] prod;
    logic [47:0] rounded;
    logic [31:0] mag;
    logic [14:0] mag_clamped;

    always_comb begin
        e_neg     = i_error[16];
        g_neg     = i_gain_q16[31];
        e_neg_val = 17'd0 - i_error;
        e_mag     = e_neg ? e_neg_val[15:0] : i_error[15:0];
        g_mag     = g_neg ? (32'd0 - i_gain_q16) : i_gain_q16;
        prod      = {32'd0, e_mag} * {16'd0, g_mag};
        // Half an output unit added before the shift rounds ties away from zero.
        rounded   = prod + 48'h0000_0000_8000;
        mag       = rounded[47:16];
        mag_clamped = (mag > {17'd0, i_limit}) ? i_limit : mag[14:0];
        o_drive   = (e_neg != g_neg) ? (16'sd0 - $signed({1'b0, mag_clamped}))
                                     : $signed({1'b0, mag_clamped});
    end

endmodule

// File: rtl/dsaa_core.sv
// Run controller: state update for one command per cycle while results are taken, and the result register.
module dsaa_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dsaa_pkg::t_cfg        i_cfg,
    input  dsaa_pkg::t_item_stage i_stage,
    output logic                  o_take,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dsaa_pkg::t_result     o_res
);
    import dsaa_pkg::*;

    t_run_state         r_state,        n_state;
    t_fault             r_fault,        n_fault;
    logic               r_phase,        n_phase;
    logic [31:0]        r_run_start,    n_run_start;
    logic [31:0]        r_settle_start, n_settle_start;
    logic               r_settling,     n_settling;
    logic signed [16:0] r_error,        n_error;
    logic signed [15:0] r_drive,        n_drive;
    logic               r_drive_valid,  n_drive_valid;
    logic               n_accepted;

    logic               r_ov;
    t_result            r_res;

    logic               fire;
    logic               params_ok;
    logic [31:0]        eff_timeout;
    logic [31:0]        eff_settle;
    logic [31:0]        run_elapsed;
    logic [31:0]        settle_elapsed;
    logic               timed_out;
    logic               in_window;
    logic signed [16:0] cur_error;
    logic [16:0]        neg_error;
    logic [15:0]        abs_error;
    logic               in_tol;
    logic signed [15:0] p_drive;

    t_item it;

    assign it     = i_stage.item;
    assign fire   = i_stage.valid && (!r_ov || i_ready);
    assign o_take = fire;

    always_comb begin
        params_ok = (i_cfg.target_count != 16'd0) && (i_cfg.tolerance_count != 16'd0)
                    && (i_cfg.drive_limit != 15'd0)
                    && (i_cfg.window_low <= i_cfg.window_high);
        eff_timeout    = (i_cfg.run_limit_ms != 32'd0) ? i_cfg.run_limit_ms
                                                       : DEFAULT_RUN_LIMIT;
        eff_settle     = (i_cfg.settle_ms != 32'd0) ? i_cfg.settle_ms : DEFAULT_SETTLE_MS;
        run_elapsed    = it.now_ms - r_run_start;
        settle_elapsed = it.now_ms - r_settle_start;
        timed_out      = run_elapsed >= eff_timeout;
        in_window      = it.sample_valid && (it.sample_count >= i_cfg.window_low)
                         && (it.sample_count <= i_cfg.window_high);
        cur_error      = $signed({1'b0, i_cfg.target_count}) - $signed({1'b0, it.sample_count});
        neg_error      = 17'd0 - cur_error;
        abs_error      = cur_error[16] ? neg_error[15:0] : cur_error[15:0];
        in_tol         = abs_error <= i_cfg.tolerance_count;
    end

    dsaa_drive u_drive (
        .i_error    (cur_error),
        .i_gain_q16 (i_cfg.gain_q16),
        .i_limit    (i_cfg.drive_limit),
        .o_drive    (p_drive)
    );

    always_comb begin
        n_state        = r_state;
        n_fault        = r_fault;
        n_phase        = r_phase;
        n_run_start    = r_run_start;
        n_settle_start = r_settle_start;
        n_settling     = r_settling;
        n_error        = r_error;
        n_drive        = r_drive;
        n_drive_valid  = r_drive_valid;
        n_accepted     = 1'b0;

        case (it.cmd)
            CMD_START: begin
                if (r_state != ST_RUN) begin
                    if (!params_ok) begin
                        n_state       = ST_FAIL;
                        n_fault       = FLT_PARAM;
                        n_drive       = '0;
                        n_drive_valid = 1'b0;
                    end else begin
                        n_state        = ST_RUN;
                        n_fault        = FLT_NONE;
                        n_phase        = 1'b0;
                        n_run_start    = it.now_ms;
                        n_settle_start = '0;
                        n_settling     = 1'b0;
                        n_error        = '0;
                        n_drive        = '0;
                        n_drive_valid  = 1'b0;
                        n_accepted     = 1'b1;
                    end
                end
            end
            CMD_UPDATE: begin
                if (r_state == ST_RUN) begin
                    if (!params_ok) begin
                        n_state       = ST_FAIL;
                        n_fault       = FLT_PARAM;
                        n_drive       = '0;
                        n_drive_valid = 1'b0;
                    end else if (!it.mech_at_target) begin
                        n_phase        = 1'b0;
                        n_settling     = 1'b0;
                        n_settle_start = '0;
                        n_drive        = '0;
                        n_drive_valid  = !timed_out;
                        if (timed_out) begin
                            n_state = ST_FAIL;
                            n_fault = FLT_TIMEOUT;
                        end
                    end else if (!in_window) begin
                        n_phase        = 1'b1;
                        n_settling     = 1'b0;
                        n_settle_start = '0;
                        n_drive        = '0;
                        n_drive_valid  = !timed_out;
                        if (timed_out) begin
                            n_state = ST_FAIL;
                            n_fault = FLT_SENSOR;
                        end
                    end else begin
                        n_phase       = 1'b1;
                        n_error       = cur_error;
                        n_drive       = in_tol ? 16'sd0 : p_drive;
                        n_drive_valid = 1'b1;
                        if (timed_out) begin
                            n_state       = ST_FAIL;
                            n_fault       = FLT_TIMEOUT;
                            n_drive       = '0;
                            n_drive_valid = 1'b0;
                        end else if (!in_tol) begin
                            n_settling     = 1'b0;
                            n_settle_start = '0;
                        end else if (!r_settling) begin
                            // First tick inside tolerance only marks the time.
                            n_settling     = 1'b1;
                            n_settle_start = it.now_ms;
                        end else if (settle_elapsed >= eff_settle) begin
                            n_state       = ST_OK;
                            n_fault       = FLT_NONE;
                            n_drive       = '0;
                            n_drive_valid = 1'b0;
                        end
                    end
                end
            end
            CMD_ABORT: begin
                n_state       = ST_ABORT;
                n_fault       = FLT_ABORT;
                n_drive       = '0;
                n_drive_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_fault        <= FLT_NONE;
            r_phase        <= 1'b0;
            r_run_start    <= '0;
            r_settle_start <= '0;
            r_settling     <= 1'b0;
            r_error        <= '0;
            r_drive        <= '0;
            r_drive_valid  <= 1'b0;
            r_ov           <= 1'b0;
        end else begin
            if (fire) begin
                r_state        <= n_state;
                r_fault        <= n_fault;
                r_phase        <= n_phase;
                r_run_start    <= n_run_start;
                r_settle_start <= n_settle_start;
                r_settling     <= n_settling;
                r_error        <= n_error;
                r_drive        <= n_drive;
                r_drive_valid  <= n_drive_valid;
                r_ov           <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res.drive          <= n_drive;
            r_res.drive_valid    <= n_drive_valid;
            r_res.run_state      <= n_state;
            r_res.outcome        <= n_state;
            r_res.fault_code     <= n_fault;
            r_res.phase          <= n_phase;
            r_res.start_accepted <= n_accepted;
            r_res.error_count    <= n_error;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

    a_dv_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive_valid |-> (r_state == ST_RUN))
        else $error("drive issued outside a run");

    a_no_drive_unless_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drive_valid |-> (r_drive == 16'sd0))
        else $error("nonzero drive without a drive command");

    a_settle_mark_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_settling |-> (r_settle_start == 32'd0))
        else $error("settle time kept while not settling");

    a_start_gives_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_accepted) |=> (r_ov && r_res.run_state == ST_RUN
                                  && r_res.fault_code == FLT_NONE))
        else $error("accepted start did not report a fresh run");

    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_ov)
        else $error("processed command left no result");

endmodule

// File: rtl/distance_sensor_axis_alignment.sv
// Top level of the single-axis distance-sensor alignment controller.
// Path: a command transaction is held in the input register, then its result is
// loaded into the result register.
// Throughput: one command transaction per cycle while results are taken; while a
// result waits, one more transaction is held in the input register, then tready drops.
// Reset: synchronous, active low; clears run state, fault, timers and drive,
// and loads the register defaults (window high 65535, timeout 5000, settle 120).
module distance_sensor_axis_alignment (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port, index is the register number.
    input  logic                                i_cfg_we,
    input  logic [dsaa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dsaa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Command stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: now_ms[31:0], mech_at_target, sample_valid,
    // sample_count[15:0], zero padding to 56 bits.
    input  logic [dsaa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [dsaa_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: drive[15:0], drive_valid, run_state[2:0], outcome[2:0],
    // fault_code[2:0], phase, start_accepted, error_count[16:0], zero padding.
    output logic [dsaa_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import dsaa_pkg::*;

    t_cfg        cfg;
    t_item       in_item;
    t_item_stage stage;
    logic        take;
    t_result     res;

    // Unpack the incoming transaction into its fields.
    assign in_item.cmd            = t_cmd'(s_axis_tuser);
    assign in_item.now_ms         = s_axis_tdata[31:0];
    assign in_item.mech_at_target = s_axis_tdata[32];
    assign in_item.sample_valid   = s_axis_tdata[33];
    assign in_item.sample_count   = s_axis_tdata[49:34];

    dsaa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The input register frees itself in the same cycle that the core takes
    // its content, so a new transaction is taken every cycle while results flow.
    dsaa_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_stage (stage),
        .i_take  (take)
    );

    // The core applies one command per cycle to the run state and loads the
    // result register; it stalls only while that register is full and unread.
    dsaa_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_stage (stage),
        .o_take  (take),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {3'd0, res.error_count, res.start_accepted, res.phase,
                           res.fault_code, res.outcome, res.run_state,
                           res.drive_valid, res.drive};

endmodule
